[src/lstg_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the load/store traffic generator
// no dependencies; used by every module of the block by scoped names

package lstg_pkg;

  // input command codes as they arrive in the stream
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ISSUE  = 2'd1;
  localparam logic [1:0] CMD_RESP   = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_BASE     = 3'd0;
  localparam logic [2:0] REG_MODE     = 3'd1;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_DO_LOADS = 3'd3;
  localparam logic [2:0] REG_LINE     = 3'd4;

  // access modes
  localparam logic [2:0] MODE_FIXED  = 3'd0;
  localparam logic [2:0] MODE_NEXT   = 3'd1;
  localparam logic [2:0] MODE_SEQ    = 3'd2;
  localparam logic [2:0] MODE_RANDOM = 3'd3;
  localparam logic [2:0] MODE_WTR    = 3'd4;

  // configuration reset values
  localparam logic [63:0] BASE_RESET     = 64'h0000_0000_B490_0000;
  localparam logic [2:0]  MODE_RESET     = MODE_SEQ;
  localparam logic [12:0] COUNT_RESET    = 13'd16;
  localparam logic        DO_LOADS_RESET = 1'b1;
  localparam logic [12:0] LINE_RESET     = 13'd64;

  localparam logic [12:0] MAX_ACCESSES = 13'd4096;
  // random line index is taken below 8192 lines, a 13-bit mask of the lfsr
  localparam int          RAND_IDX_W   = 13;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;
  localparam logic [3:0]  STATUS_DONE  = 4'd12;
  localparam logic [3:0]  STATUS_BUSY  = 4'd0;

  typedef enum logic [3:0] {
    KIND_START  = 4'b0001,
    KIND_ISSUE  = 4'b0010,
    KIND_RESP   = 4'b0100,
    KIND_STATUS = 4'b1000
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  port_accepts;
    logic  resp_is_write;
  } item_t;

  typedef struct packed {
    logic [63:0] base_address;
    logic [2:0]  access_mode;
    logic [12:0] access_count;
    logic        do_loads;
    logic [12:0] line_bytes;
  } cfg_t;

  // result item, req_valid in the lowest bit
  typedef struct packed {
    logic        bad_response;
    logic        finished;
    logic [3:0]  status_word;
    logic        req_is_read;
    logic [63:0] req_address;
    logic        req_valid;
  } res_t;

endpackage

[src/lstg_front.sv]
`timescale 1ns / 1ps
// front end: takes input transactions and classifies the command
// depends on lstg_pkg; feeds lstg_queue

module lstg_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                q_full,
  output logic                push,
  output lstg_pkg::item_t     push_item
);

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_item.port_accepts  = in_tdata[2];
    push_item.resp_is_write = in_tdata[3];
    case (in_tdata[1:0])
      lstg_pkg::CMD_START:  push_item.kind = lstg_pkg::KIND_START;
      lstg_pkg::CMD_ISSUE:  push_item.kind = lstg_pkg::KIND_ISSUE;
      lstg_pkg::CMD_RESP:   push_item.kind = lstg_pkg::KIND_RESP;
      lstg_pkg::CMD_STATUS: push_item.kind = lstg_pkg::KIND_STATUS;
      default:              push_item.kind = lstg_pkg::KIND_STATUS;
    endcase
  end

endmodule

[src/lstg_queue.sv]
`timescale 1ns / 1ps
// short queue of classified items between front and back
// depends on lstg_pkg

module lstg_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lstg_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lstg_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lstg_pkg::item_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/lstg_back.sv]
`timescale 1ns / 1ps
// back end: run phases, request address generation, response counting
// depends on lstg_pkg; pops lstg_queue and drives the result register

module lstg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  lstg_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  lstg_pkg::item_t head_item,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RUN  = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // fresh addresses take an extra step: offset product, then the base add
  typedef enum logic [1:0] {
    SEQ_EXEC = 2'b01,
    SEQ_ADDR = 2'b10
  } seq_t;

  phase_t         phase_r, phase_nxt;
  seq_t           seq_r, seq_nxt;
  logic [13:0]    issued_r, issued_nxt;
  logic [13:0]    recv_r, recv_nxt;
  logic [13:0]    wrecv_r, wrecv_nxt;
  logic [63:0]    held_addr_r, held_addr_nxt;
  logic           held_r, held_nxt;
  logic [15:0]    lfsr_r, lfsr_nxt;
  logic [26:0]    offset_r, offset_nxt;
  logic           out_valid_r, out_valid_nxt;
  lstg_pkg::res_t out_data_r, out_data_nxt;

  logic [12:0]    n_eff;
  logic [13:0]    n_ext;
  logic [13:0]    total;
  logic           is_wtr;
  logic [13:0]    line_idx;
  logic [26:0]    offset_prod;
  logic [63:0]    new_addr;
  logic [63:0]    addr_use;
  logic [15:0]    lfsr_step;
  logic           need_form;
  logic           out_free;
  logic           exec;
  logic [13:0]    issued_inc;
  logic [13:0]    recv_inc;
  logic [13:0]    wrecv_inc;
  lstg_pkg::res_t res;

  assign is_wtr = (cfg.access_mode == lstg_pkg::MODE_WTR);

  always_comb begin
    if (cfg.access_count == '0) begin
      n_eff = 13'd1;
    end else if (cfg.access_count > lstg_pkg::MAX_ACCESSES) begin
      n_eff = lstg_pkg::MAX_ACCESSES;
    end else begin
      n_eff = cfg.access_count;
    end
  end

  assign n_ext      = {1'b0, n_eff};
  assign total      = is_wtr ? {n_eff, 1'b0} : n_ext;
  assign issued_inc = issued_r + 14'd1;
  assign recv_inc   = recv_r + 14'd1;
  assign wrecv_inc  = wrecv_r + 14'd1;

  // taps 16, 14, 13, 11
  assign lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};

  always_comb begin
    case (cfg.access_mode)
      lstg_pkg::MODE_NEXT:   line_idx = 14'd1;
      lstg_pkg::MODE_SEQ:    line_idx = issued_r;
      lstg_pkg::MODE_RANDOM: line_idx = 14'(lfsr_r[lstg_pkg::RAND_IDX_W-1:0]);
      // write-then-read: issued is below 2n whenever an address is formed, so the wrap is one subtract
      lstg_pkg::MODE_WTR:    line_idx = (issued_r >= n_ext) ? issued_r - n_ext : issued_r;
      default:               line_idx = 14'd0;
    endcase
  end

  assign offset_prod = {13'd0, line_idx} * {14'd0, cfg.line_bytes};
  assign new_addr    = cfg.base_address + {37'd0, offset_r};
  assign addr_use    = held_r ? held_addr_r : new_addr;

  assign out_free  = !out_valid_r || out_tready;
  assign need_form = head_valid && (head_item.kind == lstg_pkg::KIND_ISSUE)
                     && (phase_r == PH_RUN) && (issued_r < total) && !held_r;

  always_comb begin
    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    issued_nxt    = issued_r;
    recv_nxt      = recv_r;
    wrecv_nxt     = wrecv_r;
    held_addr_nxt = held_addr_r;
    held_nxt      = held_r;
    lfsr_nxt      = lfsr_r;
    offset_nxt    = offset_r;
    exec          = 1'b0;
    res           = '0;

    case (seq_r)
      SEQ_EXEC: begin
        if (need_form) begin
          offset_nxt = offset_prod;
          if (cfg.access_mode == lstg_pkg::MODE_RANDOM) begin
            lfsr_nxt = lfsr_step;
          end
          seq_nxt = SEQ_ADDR;
        end else if (head_valid && out_free) begin
          exec = 1'b1;
        end
      end
      SEQ_ADDR: begin
        if (out_free) begin
          exec    = 1'b1;
          seq_nxt = SEQ_EXEC;
        end
      end
      default: seq_nxt = SEQ_EXEC;
    endcase

    if (exec) begin
      case (head_item.kind)
        lstg_pkg::KIND_START: begin
          if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
            issued_nxt = '0;
            recv_nxt   = '0;
            wrecv_nxt  = '0;
            held_nxt   = 1'b0;
            phase_nxt  = PH_RUN;
          end
        end
        lstg_pkg::KIND_ISSUE: begin
          if (phase_r == PH_RUN && issued_r < total) begin
            held_addr_nxt   = addr_use;
            held_nxt        = 1'b1;
            res.req_valid   = 1'b1;
            res.req_address = addr_use;
            res.req_is_read = is_wtr ? (issued_r >= n_ext) : cfg.do_loads;
            if (head_item.port_accepts) begin
              issued_nxt = issued_inc;
              held_nxt   = 1'b0;
              if (is_wtr && issued_inc == n_ext && wrecv_r < n_ext) begin
                phase_nxt = PH_WAIT;
              end
            end
          end
        end
        lstg_pkg::KIND_RESP: begin
          if (phase_r == PH_IDLE) begin
            res.bad_response = 1'b1;
          end else if (phase_r != PH_DONE) begin
            if (head_item.resp_is_write) begin
              wrecv_nxt = wrecv_inc;
              if (phase_r == PH_WAIT && wrecv_inc >= n_ext) begin
                phase_nxt = PH_RUN;
              end
            end
            recv_nxt = recv_inc;
            if (recv_inc >= total) begin
              phase_nxt = PH_DONE;
              held_nxt  = 1'b0;
            end
          end
        end
        default: ;
      endcase
      res.finished    = (phase_nxt == PH_DONE);
      res.status_word = (phase_nxt == PH_DONE) ? lstg_pkg::STATUS_DONE
                                               : lstg_pkg::STATUS_BUSY;
    end
  end

  assign pop           = exec;
  assign out_valid_nxt = exec ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_data_nxt  = exec ? res : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seq_r       <= SEQ_EXEC;
      issued_r    <= '0;
      recv_r      <= '0;
      wrecv_r     <= '0;
      held_r      <= 1'b0;
      lfsr_r      <= lstg_pkg::LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      issued_r    <= issued_nxt;
      recv_r      <= recv_nxt;
      wrecv_r     <= wrecv_nxt;
      held_r      <= held_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_addr_r <= held_addr_nxt;
    offset_r    <= offset_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the address step always finishes an item still at the queue head
  a_addr_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SEQ_ADDR |-> head_valid)
    else $error("address step without a queued item");

  a_addr_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_ADDR && out_free) |=> seq_r == SEQ_EXEC)
    else $error("address step did not complete");

  // a held request only exists while running
  a_held_running: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> phase_r == PH_RUN)
    else $error("held address outside the running phase");

  a_bad_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && head_item.kind == lstg_pkg::KIND_RESP && phase_r == PH_IDLE)
    |=> (out_valid_r && out_data_r.bad_response))
    else $error("idle response not flagged");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && head_item.kind == lstg_pkg::KIND_START)
    |=> (phase_r == PH_RUN || phase_r == PH_WAIT))
    else $error("start did not leave the block running");

endmodule

[src/load_store_traffic_generator.sv]
`timescale 1ns / 1ps
// path: an accepted transaction passes the queue, then the result register; an issue
// slot that forms a fresh address also passes the offset register in between
// throughput: one transaction per cycle while the result side accepts and no fresh address is
// formed; a fresh-address issue slot takes an extra back-end step (offset multiply, then base add)
// reset: rst_n synchronous active low; registers to defaults, counters cleared,
// run phase idle, lfsr 0xace1, queue and result register empty
// depends on lstg_pkg, lstg_front, lstg_queue, lstg_back

module load_store_traffic_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // command[1:0], port_accepts[2], resp_is_write[3], zero[7:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // req_valid[0], req_address[64:1], req_is_read[65],
                                  // status_word[69:66], finished[70], bad_response[71]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  lstg_pkg::cfg_t  cfg_r, cfg_nxt;
  logic            q_full;
  logic            push;
  lstg_pkg::item_t push_item;
  logic            pop;
  logic            head_valid;
  lstg_pkg::item_t head_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lstg_pkg::REG_BASE:     cfg_nxt.base_address = cfg_data;
        lstg_pkg::REG_MODE:     cfg_nxt.access_mode  = cfg_data[2:0];
        lstg_pkg::REG_COUNT:    cfg_nxt.access_count = cfg_data[12:0];
        lstg_pkg::REG_DO_LOADS: cfg_nxt.do_loads     = cfg_data[0];
        lstg_pkg::REG_LINE:     cfg_nxt.line_bytes   = cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= lstg_pkg::BASE_RESET;
      cfg_r.access_mode  <= lstg_pkg::MODE_RESET;
      cfg_r.access_count <= lstg_pkg::COUNT_RESET;
      cfg_r.do_loads     <= lstg_pkg::DO_LOADS_RESET;
      cfg_r.line_bytes   <= lstg_pkg::LINE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lstg_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lstg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lstg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[test/load_store_traffic_generator_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the load/store traffic generator: a directed table, then random runs
// outcomes come from a behavioral model in this file or from pinned rows; needs lstg_pkg

module load_store_traffic_generator_tb;

  localparam int RANDOM_COMMANDS = 1900;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_CYCLES     = 120;

  typedef enum logic [3:0] {
    RUN_IDLE       = 4'b0001,
    RUN_BUSY       = 4'b0010,
    RUN_WRITE_WAIT = 4'b0100,
    RUN_FINISHED   = 4'b1000
  } run_phase_t;

  typedef struct {
    bit             is_cfg;
    logic [2:0]     idx;
    logic [63:0]    data;
    logic [1:0]     cmd;
    logic           acc;
    logic           rw;
    bit             typed;
    lstg_pkg::res_t want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // command[1:0], port_accepts[2], resp_is_write[3], zero[7:4]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // req_valid[0], req_address[64:1], req_is_read[65],
                           // status_word[69:66], finished[70], bad_response[71]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // generator model: live registers and run state
  logic [63:0] m_base      = lstg_pkg::BASE_RESET;
  logic [2:0]  m_mode      = lstg_pkg::MODE_RESET;
  logic [12:0] m_count     = lstg_pkg::COUNT_RESET;
  logic        m_loads     = lstg_pkg::DO_LOADS_RESET;
  logic [12:0] m_line      = lstg_pkg::LINE_RESET;
  int          m_issued    = 0;
  int          m_received  = 0;
  int          m_writes    = 0;
  run_phase_t  m_phase     = RUN_IDLE;
  logic [63:0] m_held_addr = '0;
  logic        m_addr_held = 1'b0;
  logic [15:0] m_lfsr      = lstg_pkg::LFSR_SEED;

  lstg_pkg::res_t pending_outcomes[$];
  plan_row_t      plan[$];
  bit             pinned_valid = 1'b0;
  lstg_pkg::res_t pinned_outcome;
  lstg_pkg::res_t mon_outcome;
  lstg_pkg::res_t mon_got;
  lstg_pkg::res_t mon_want;
  int             mismatch_count = 0;
  int             commands_sent = 0;
  int             outcomes_seen = 0;
  int             cycle_count = 0;
  bit             send_calm = 1'b0;
  bit             recv_calm = 1'b0;

  load_store_traffic_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int lines_per_run();
    if (m_count == 13'd0) return 1;
    if (m_count > lstg_pkg::MAX_ACCESSES) return int'(lstg_pkg::MAX_ACCESSES);
    return int'(m_count);
  endfunction

  function automatic int responses_per_run();
    return (m_mode == lstg_pkg::MODE_WTR) ? 2 * lines_per_run() : lines_per_run();
  endfunction

  function automatic logic [63:0] fresh_address();
    logic [63:0] stride;
    logic [63:0] idx;
    logic        fb;
    stride = 64'(m_line);
    case (m_mode)
      lstg_pkg::MODE_NEXT: return m_base + stride;
      lstg_pkg::MODE_SEQ:  return m_base + 64'(m_issued) * stride;
      lstg_pkg::MODE_RANDOM: begin
        idx = 64'(m_lfsr[lstg_pkg::RAND_IDX_W-1:0]);
        fb = m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5];
        m_lfsr = {fb, m_lfsr[15:1]};
        return m_base + idx * stride;
      end
      lstg_pkg::MODE_WTR:  return m_base + 64'(m_issued % lines_per_run()) * stride;
      default:             return m_base;
    endcase
  endfunction

  // advances the model by one command and returns what the generator shows for it
  function automatic lstg_pkg::res_t command_outcome(logic [1:0] cmd, logic acc, logic rw);
    lstg_pkg::res_t r;
    r = '0;
    case (cmd)
      lstg_pkg::CMD_START: begin
        if (m_phase == RUN_IDLE || m_phase == RUN_FINISHED) begin
          m_issued = 0;
          m_received = 0;
          m_writes = 0;
          m_addr_held = 1'b0;
          m_held_addr = '0;
          m_phase = RUN_BUSY;
        end
      end
      lstg_pkg::CMD_ISSUE: begin
        if (m_phase == RUN_BUSY && m_issued < responses_per_run()) begin
          if (!m_addr_held) begin
            m_held_addr = fresh_address();
            m_addr_held = 1'b1;
          end
          r.req_valid = 1'b1;
          r.req_address = m_held_addr;
          if (m_mode == lstg_pkg::MODE_WTR) r.req_is_read = (m_issued >= lines_per_run());
          else r.req_is_read = m_loads;
          if (acc) begin
            m_issued++;
            m_addr_held = 1'b0;
            if (m_mode == lstg_pkg::MODE_WTR && m_issued == lines_per_run()
                && m_writes < lines_per_run())
              m_phase = RUN_WRITE_WAIT;
          end
        end
      end
      lstg_pkg::CMD_RESP: begin
        if (m_phase == RUN_IDLE) begin
          r.bad_response = 1'b1;
        end else if (m_phase != RUN_FINISHED) begin
          if (rw) begin
            m_writes++;
            if (m_phase == RUN_WRITE_WAIT && m_writes >= lines_per_run()) m_phase = RUN_BUSY;
          end
          m_received++;
          if (m_received >= responses_per_run()) begin
            m_phase = RUN_FINISHED;
            m_addr_held = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.finished = (m_phase == RUN_FINISHED);
    r.status_word = r.finished ? lstg_pkg::STATUS_DONE : lstg_pkg::STATUS_BUSY;
    return r;
  endfunction

  function automatic lstg_pkg::res_t outcome_of(logic valid, logic [63:0] addr, logic rd,
                                                logic fin, logic bad);
    lstg_pkg::res_t r;
    r.req_valid = valid;
    r.req_address = addr;
    r.req_is_read = rd;
    r.finished = fin;
    r.status_word = fin ? lstg_pkg::STATUS_DONE : lstg_pkg::STATUS_BUSY;
    r.bad_response = bad;
    return r;
  endfunction

  function automatic void add_reg(logic [2:0] idx, logic [63:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, cmd: lstg_pkg::CMD_STATUS, acc: 1'b0,
            rw: 1'b0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_cmd(logic [1:0] cmd, logic acc, logic rw, bit typed,
                                  lstg_pkg::res_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, idx: lstg_pkg::REG_BASE, data: '0, cmd: cmd, acc: acc, rw: rw,
            typed: typed, want: want};
    plan.push_back(row);
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    // back-to-back traffic while the receiver holds off, so the block fills up
    if ((commands_sent >= 395 && commands_sent < 470)
        || (commands_sent >= 1295 && commands_sent < 1370))
      return 0;
    return send_calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("ERROR at %0t, result %0d, %s: got %h, want %h", $realtime, outcomes_seen,
             what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_command(logic [1:0] cmd, logic acc, logic rw, int gap, bit pin,
                              lstg_pkg::res_t want);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_valid = pin;
    pinned_outcome = want;
    in_tdata <= {4'b0000, rw, acc, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(1, 3)) @(negedge clk);
  endtask

  // block is idle once every outcome is back; the task then waits on to cover the back end
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // model updates and result checking
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        lstg_pkg::REG_BASE:     m_base = cfg_data;
        lstg_pkg::REG_MODE:     m_mode = cfg_data[2:0];
        lstg_pkg::REG_COUNT:    m_count = cfg_data[12:0];
        lstg_pkg::REG_DO_LOADS: m_loads = cfg_data[0];
        lstg_pkg::REG_LINE:     m_line = cfg_data[12:0];
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) begin
      mon_outcome = command_outcome(in_tdata[1:0], in_tdata[2], in_tdata[3]);
      if (pinned_valid) mon_outcome = pinned_outcome;
      pinned_valid = 1'b0;
      pending_outcomes.push_back(mon_outcome);
      commands_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = out_tdata;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[63:0], '0);
      end else begin
        mon_want = pending_outcomes.pop_front();
        check_field("req_valid", 64'(mon_got.req_valid), 64'(mon_want.req_valid));
        check_field("req_address", mon_got.req_address, mon_want.req_address);
        check_field("req_is_read", 64'(mon_got.req_is_read), 64'(mon_want.req_is_read));
        check_field("status_word", 64'(mon_got.status_word), 64'(mon_want.status_word));
        check_field("finished", 64'(mon_got.finished), 64'(mon_want.finished));
        check_field("bad_response", 64'(mon_got.bad_response), 64'(mon_want.bad_response));
      end
      outcomes_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("load_store_traffic_generator: mismatch");
      $finish;
    end
  end

  // result side: random stalls, calm stretches, and long hold-offs
  initial begin
    int gap;
    int next_hold;
    next_hold = 400;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      if (outcomes_seen >= next_hold) begin
        gap = HOLD_CYCLES;
        next_hold = next_hold + 900;
      end else begin
        gap = recv_calm ? 0 : $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int          pick;
    int          run_len;
    int          cut_at;
    int          retune_at;
    int          random_sent;
    logic [63:0] base;
    logic [2:0]  mode;
    logic [12:0] count;
    logic [12:0] line;
    logic [1:0]  cmd;
    logic        acc;
    logic        rw;
    logic        can_issue;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    random_sent = 0;

    add_cmd(lstg_pkg::CMD_STATUS, 1'b0, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b0, 1'b0));
    // response while idle
    add_cmd(lstg_pkg::CMD_RESP, 1'b0, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b0, 1'b1));
    // nothing to issue yet
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b0, 1'b0));
    add_reg(lstg_pkg::REG_BASE, '1);
    add_reg(lstg_pkg::REG_LINE, 64'h1FFF);
    add_reg(lstg_pkg::REG_MODE, 64'(lstg_pkg::MODE_NEXT));
    add_reg(lstg_pkg::REG_COUNT, 64'd0);                       // clamps to one access
    add_reg(lstg_pkg::REG_DO_LOADS, 64'd0);
    add_cmd(lstg_pkg::CMD_START, 1'b0, 1'b0, 1'b0, '0);
    // address wraps, refused
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b0, 1'b0, 1'b1,
            outcome_of(1'b1, 64'h1FFE, 1'b0, 1'b0, 1'b0));
    // retry keeps address
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b1,
            outcome_of(1'b1, 64'h1FFE, 1'b0, 1'b0, 1'b0));
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b0, 1'b0));
    add_cmd(lstg_pkg::CMD_START, 1'b1, 1'b1, 1'b0, '0);        // ignored while busy
    add_cmd(lstg_pkg::CMD_RESP, 1'b0, 1'b1, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b1, 1'b0));
    // late response, dropped
    add_cmd(lstg_pkg::CMD_RESP, 1'b0, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b1, 1'b0));
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b1, 1'b0));
    add_reg(lstg_pkg::REG_MODE, 64'd7);                        // undefined mode acts as fixed
    add_reg(lstg_pkg::REG_LINE, 64'd0);
    add_reg(lstg_pkg::REG_BASE, 64'd0);
    add_reg(lstg_pkg::REG_COUNT, 64'h1FFF);                    // clamps to the maximum
    add_reg(lstg_pkg::REG_DO_LOADS, 64'd1);
    add_cmd(lstg_pkg::CMD_START, 1'b0, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b1,
            outcome_of(1'b1, 64'd0, 1'b1, 1'b0, 1'b0));
    add_reg(lstg_pkg::REG_COUNT, 64'd1);                       // shrink while running
    add_cmd(lstg_pkg::CMD_RESP, 1'b0, 1'b0, 1'b1,
            outcome_of(1'b0, 64'd0, 1'b0, 1'b1, 1'b0));
    add_reg(lstg_pkg::REG_MODE, 64'(lstg_pkg::MODE_WTR));
    add_reg(lstg_pkg::REG_COUNT, 64'd2);
    add_reg(lstg_pkg::REG_BASE, 64'h1000);
    add_reg(lstg_pkg::REG_LINE, 64'h40);
    add_cmd(lstg_pkg::CMD_START, 1'b0, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_RESP,  1'b0, 1'b1, 1'b0, '0);        // write completes early
    add_cmd(lstg_pkg::CMD_RESP,  1'b0, 1'b1, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b0, '0);        // goes straight to reads
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_RESP,  1'b0, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_RESP,  1'b0, 1'b0, 1'b0, '0);
    add_reg(lstg_pkg::REG_MODE, 64'(lstg_pkg::MODE_RANDOM));
    add_reg(lstg_pkg::REG_LINE, 64'd1);
    add_cmd(lstg_pkg::CMD_START, 1'b0, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b0, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_ISSUE, 1'b1, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_RESP,  1'b0, 1'b0, 1'b0, '0);
    add_cmd(lstg_pkg::CMD_RESP,  1'b0, 1'b0, 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_quiet();
        write_register(plan[i].idx, plan[i].data);
      end else begin
        send_command(plan[i].cmd, plan[i].acc, plan[i].rw, sender_gap(), plan[i].typed,
                     plan[i].want);
      end
    end

    while (random_sent < RANDOM_COMMANDS) begin
      wait_quiet();
      pick = $urandom_range(0, 99);
      if (pick < 70) count = 13'($urandom_range(1, 8));
      else if (pick < 88) count = 13'($urandom_range(9, 40));
      else if (pick < 94) count = 13'd0;
      else count = 13'($urandom_range(4090, 8191));
      pick = $urandom_range(0, 10);
      mode = (pick > 7) ? lstg_pkg::MODE_WTR : 3'(pick);
      case ($urandom_range(0, 4))
        0: base = '0;
        1: base = '1 - 64'($urandom_range(0, 4095));
        2: base = lstg_pkg::BASE_RESET;
        default: base = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
        0: line = 13'd0;
        1: line = 13'h1FFF;
        2: line = 13'd64;
        3: line = 13'd4096;
        default: line = 13'($urandom_range(1, 255));
      endcase
      write_register(lstg_pkg::REG_BASE, base);
      write_register(lstg_pkg::REG_MODE, 64'(mode));
      write_register(lstg_pkg::REG_COUNT, 64'(count));
      write_register(lstg_pkg::REG_DO_LOADS, 64'($urandom_range(0, 1)));
      write_register(lstg_pkg::REG_LINE, 64'(line));

      // large runs are cut short by lowering the count while running
      cut_at = (count > 13'd40) ? 30 : 300;
      retune_at = ($urandom_range(0, 6) == 0) ? $urandom_range(2, 20) : -1;
      run_len = 0;

      while ($urandom_range(0, 4) == 0) begin
        send_command(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), sender_gap(), 1'b0, '0);
        random_sent++;
      end
      send_command(lstg_pkg::CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   sender_gap(), 1'b0, '0);
      random_sent++;

      while (m_phase != RUN_FINISHED) begin
        if (run_len == retune_at) begin
          wait_quiet();
          write_register(lstg_pkg::REG_BASE, {$urandom, $urandom});
          write_register(lstg_pkg::REG_LINE, 64'($urandom_range(0, 8191)));
        end
        if (run_len == cut_at) begin
          wait_quiet();
          write_register(lstg_pkg::REG_COUNT, 64'd1);
        end
        pick = $urandom_range(0, 99);
        can_issue = (m_phase == RUN_BUSY) && (m_issued < responses_per_run());
        if (pick < 3) cmd = lstg_pkg::CMD_START;
        else if (pick < 10) cmd = lstg_pkg::CMD_STATUS;
        else if (can_issue && (pick < 60 || m_received >= m_issued)) cmd = lstg_pkg::CMD_ISSUE;
        else cmd = lstg_pkg::CMD_RESP;
        acc = ($urandom_range(0, 3) != 0);
        if (m_mode == lstg_pkg::MODE_WTR) rw = (m_writes < lines_per_run());
        else rw = !m_loads;
        if ($urandom_range(0, 9) == 0) rw = 1'($urandom_range(0, 1));
        send_command(cmd, acc, rw, sender_gap(), 1'b0, '0);
        random_sent++;
        run_len++;
      end

      // a little noise after the run has finished
      while ($urandom_range(0, 5) == 0) begin
        send_command(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), sender_gap(), 1'b0, '0);
        random_sent++;
      end
    end

    wait_quiet();
    repeat (6) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("load_store_traffic_generator: match");
    end else begin
      $display("load_store_traffic_generator: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
src/lstg_pkg.sv
src/lstg_front.sv
src/lstg_queue.sv
src/lstg_back.sv
src/load_store_traffic_generator.sv
test/load_store_traffic_generator_tb.sv
